/* sv/pwm_duty_period_capture_core_macros.svh */
// assertion macros for the pwm duty/period capture block
// used by the top level only, no other dependencies
`ifndef PWM_DUTY_PERIOD_CAPTURE_CORE_MACROS_SVH
`define PWM_DUTY_PERIOD_CAPTURE_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define PDPC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdpc assertion failed");

// next-cycle implication, held off during reset
`define PDPC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdpc assertion failed");

`endif

/* sv/pdpc_pkg.sv */
// shared types and constants for the pwm duty/period capture block
// no dependencies
`timescale 1ns / 1ps

package pdpc_pkg;

  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned RES_W      = 16;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(20160 / 13);

  localparam logic [STATUS_W-1:0] ST_MEASURED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONST_LOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONST_HIGH = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] capture_status;
    logic [RES_W-1:0]    high_width;
    logic [RES_W-1:0]    period_width;
  } result_t;

endpackage

/* sv/pdpc_sample_if.sv */
// input channel carrying one pwm level sample per transaction
// depends on nothing
`timescale 1ns / 1ps

interface pdpc_sample_if;
  logic valid;
  logic ready;
  logic pwm_level;

  modport source (output valid, output pwm_level, input ready);
  modport sink (input valid, input pwm_level, output ready);
endinterface

/* sv/pdpc_result_if.sv */
// output channel carrying one capture result per transaction
// depends on pdpc_pkg
`timescale 1ns / 1ps

interface pdpc_result_if;
  logic                                valid;
  logic                                ready;
  logic [pdpc_pkg::STATUS_W-1:0]       capture_status;
  logic [pdpc_pkg::RES_W-1:0]          high_width;
  logic [pdpc_pkg::RES_W-1:0]          period_width;

  modport source (output valid, output capture_status, output high_width,
                  output period_width, input ready);
  modport sink (input valid, input capture_status, input high_width,
                input period_width, output ready);
endinterface

/* sv/pdpc_meas.sv */
// measurement state machine: phase tracking, timeout countdown and width counters
// depends on pdpc_pkg
`timescale 1ns / 1ps

module pdpc_meas #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   level,
  input  logic [COUNT_WIDTH-1:0] limit,
  output logic                   emit,
  output pdpc_pkg::result_t      res
);

  typedef enum logic [1:0] {
    CAPTURE,
    WAIT_EDGE,
    OPPOSITE,
    RETURN
  } phase_t;

  phase_t                 phase, phase_next;
  logic                   start_level, start_level_next;
  logic [COUNT_WIDTH-1:0] wait_countdown, wait_countdown_next;
  logic [COUNT_WIDTH-1:0] first_width, first_width_next;
  logic [COUNT_WIDTH-1:0] full_width, full_width_next;

  logic [COUNT_WIDTH-1:0] cd_dec;
  logic [COUNT_WIDTH-1:0] first_inc;
  logic [COUNT_WIDTH-1:0] full_inc;
  logic [COUNT_WIDTH-1:0] hi_raw;
  logic [COUNT_WIDTH+pdpc_pkg::RES_W-1:0] hi_ext;
  logic [COUNT_WIDTH+pdpc_pkg::RES_W-1:0] per_ext;
  logic [pdpc_pkg::STATUS_W-1:0] same_kind;
  logic [pdpc_pkg::STATUS_W-1:0] opposite_kind;
  logic                   same;

  assign cd_dec    = wait_countdown - COUNT_WIDTH'(1);
  assign first_inc = first_width + COUNT_WIDTH'(1);
  assign full_inc  = full_width + COUNT_WIDTH'(1);
  assign same      = (level == start_level);
  assign same_kind     = start_level ? pdpc_pkg::ST_CONST_HIGH : pdpc_pkg::ST_CONST_LOW;
  assign opposite_kind = start_level ? pdpc_pkg::ST_CONST_LOW : pdpc_pkg::ST_CONST_HIGH;
  assign hi_raw    = start_level ? (full_width - first_width) : first_width;
  assign hi_ext    = {{pdpc_pkg::RES_W{1'b0}}, hi_raw};
  assign per_ext   = {{pdpc_pkg::RES_W{1'b0}}, full_width};

  always_comb begin
    phase_next          = phase;
    start_level_next    = start_level;
    wait_countdown_next = wait_countdown;
    first_width_next    = first_width;
    full_width_next     = full_width;
    emit                = 1'b0;
    res.capture_status  = pdpc_pkg::ST_MEASURED;
    res.high_width      = '0;
    res.period_width    = '0;
    case (phase)
      CAPTURE: begin
        start_level_next    = level;
        wait_countdown_next = limit;
        first_width_next    = '0;
        full_width_next     = '0;
        phase_next          = WAIT_EDGE;
      end
      WAIT_EDGE: begin
        if (same) begin
          wait_countdown_next = cd_dec;
          if (cd_dec == '0) begin
            emit               = 1'b1;
            res.capture_status = same_kind;
          end
        end else begin
          first_width_next = COUNT_WIDTH'(1);
          if (limit == COUNT_WIDTH'(1)) begin
            emit               = 1'b1;
            res.capture_status = opposite_kind;
          end else begin
            phase_next = OPPOSITE;
          end
        end
      end
      OPPOSITE: begin
        if (!same) begin
          first_width_next = first_inc;
          if (first_inc == limit) begin
            emit               = 1'b1;
            res.capture_status = opposite_kind;
          end
        end else begin
          full_width_next = first_inc;
          if (first_inc == limit) begin
            emit               = 1'b1;
            res.capture_status = same_kind;
          end else begin
            phase_next = RETURN;
          end
        end
      end
      RETURN: begin
        if (same) begin
          full_width_next = full_inc;
          if (full_inc == limit) begin
            emit               = 1'b1;
            res.capture_status = same_kind;
          end
        end else begin
          emit             = 1'b1;
          res.high_width   = hi_ext[pdpc_pkg::RES_W-1:0];
          res.period_width = per_ext[pdpc_pkg::RES_W-1:0];
        end
      end
      default: begin
        phase_next = CAPTURE;
      end
    endcase
    if (emit) begin
      phase_next = CAPTURE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= CAPTURE;
      start_level    <= 1'b0;
      wait_countdown <= '0;
      first_width    <= '0;
      full_width     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      start_level    <= start_level_next;
      wait_countdown <= wait_countdown_next;
      first_width    <= first_width_next;
      full_width     <= full_width_next;
    end
  end

endmodule

/* sv/pdpc_out_stage.sv */
// result register between the measurement logic and the output channel
// depends on pdpc_pkg
`timescale 1ns / 1ps

module pdpc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  pdpc_pkg::result_t load_data,
  input  logic              ready,
  output logic              valid,
  output pdpc_pkg::result_t data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

/* sv/pwm_duty_period_capture_core.sv */
// pwm duty/period capture: one level sample per transaction in, zero or one result out
// the sample that ends a measurement passes the sample register, then the result register, before its result is shown
// throughput: one sample per cycle while the result side is not stalled
// the sample register and the result register set the two stages
// synchronous active-high reset clears phase, counters and valid flags, timeout to 1550
// depends on pdpc_pkg, pdpc_sample_if, pdpc_result_if, pdpc_meas, pdpc_out_stage and the assertion macros header
`timescale 1ns / 1ps
`include "pwm_duty_period_capture_core_macros.svh"

module pwm_duty_period_capture_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [pdpc_pkg::TIMEOUT_W-1:0]   cfg_wr_data,
  pdpc_sample_if.sink                      sample,
  pdpc_result_if.source                    result
);

  logic [pdpc_pkg::TIMEOUT_W-1:0] timeout_samples;
  logic [COUNT_WIDTH+pdpc_pkg::TIMEOUT_W-1:0] limit_ext;
  logic [COUNT_WIDTH-1:0] limit;

  logic s1_valid;
  logic s1_level;
  logic s1_adv;
  logic emit;
  logic out_valid;
  pdpc_pkg::result_t step_res;
  pdpc_pkg::result_t out_data;

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_samples <= pdpc_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_samples <= cfg_wr_data;
    end
  end

  assign limit_ext = {{COUNT_WIDTH{1'b0}}, timeout_samples};
  assign limit     = limit_ext[COUNT_WIDTH-1:0];

  // sample register
  assign s1_adv       = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_level <= sample.pwm_level;
    end
  end

  pdpc_meas #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_meas (
    .clk   (clk),
    .rst   (rst),
    .step  (s1_adv),
    .level (s1_level),
    .limit (limit),
    .emit  (emit),
    .res   (step_res)
  );

  pdpc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_adv && emit),
    .load_data (step_res),
    .ready     (result.ready),
    .valid     (out_valid),
    .data      (out_data)
  );

  assign result.valid          = out_valid;
  assign result.capture_status = out_data.capture_status;
  assign result.high_width     = out_data.high_width;
  assign result.period_width   = out_data.period_width;

  `PDPC_ASSERT_IMP(a_const_zero_widths, clk, rst,
    out_valid && (out_data.capture_status != pdpc_pkg::ST_MEASURED),
    (out_data.high_width == '0) && (out_data.period_width == '0))
  `PDPC_ASSERT_IMP(a_result_from_step, clk, rst, $rose(out_valid), $past(s1_adv))
  `PDPC_ASSERT_NXT(a_sample_held, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_level))

endmodule
